/* design/lbc_pkg.sv */
package lbc_pkg;

	// field widths fixed by the request and result formats
	localparam int BLK_W = 31;
	localparam int CNT_W = 16;
	localparam int FLC_W = 5;
	localparam int SLOT_W = 4;

	// operation codes
	localparam logic [1:0] F_READ = 2'd0;
	localparam logic [1:0] F_NEW = 2'd1;
	localparam logic [1:0] F_TOUCH = 2'd2;
	localparam logic [1:0] F_FLUSH = 2'd3;

	// result kinds
	localparam logic [1:0] K_RESP = 2'd0;
	localparam logic [1:0] K_WB = 2'd1;
	localparam logic [1:0] K_FILL = 2'd2;

	// word formats the datapath can load into the output register
	localparam logic [2:0] EM_RESP = 3'd0;
	localparam logic [2:0] EM_WB_PLAIN = 3'd1;
	localparam logic [2:0] EM_WB_A = 3'd2;
	localparam logic [2:0] EM_WB_B = 3'd3;
	localparam logic [2:0] EM_FILL_PLAIN = 3'd4;
	localparam logic [2:0] EM_FILL_A = 3'd5;
	localparam logic [2:0] EM_FILL_B = 3'd6;

	// register indexes
	localparam logic REG_COMPACT = 1'b0;
	localparam logic REG_FBB = 1'b1;

	typedef struct packed {
		logic       latch_in;
		logic       scan_start;
		logic       read_old;
		logic       div_start;
		logic       div_src_tag;
		logic       make_recent;
		logic       touch;
		logic       alloc;
		logic       evict;
		logic       new_write;
		logic       flush_dec;
		logic       hit_inc;
		logic       miss_inc;
		logic       emit;
		logic [2:0] emit_code;
	} cmd_t;

	typedef struct packed {
		logic       scan_done;
		logic       hit;
		logic       free_found;
		logic       old_dirty;
		logic       cnt_zero;
		logic       fcnt_zero;
		logic       div_done;
		logic       wb_split;
		logic       fill_split;
		logic       out_free;
		logic       compact;
		logic [1:0] func;
	} status_t;

endpackage

/* design/lbc_ifs.sv */
interface lbc_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 func;
	logic [lbc_pkg::BLK_W-1:0]  block_number;
	logic [lbc_pkg::CNT_W-1:0]  byte_count;
	logic [lbc_pkg::FLC_W-1:0]  flush_count;

	modport source (output valid, func, block_number, byte_count, flush_count, input ready);
	modport sink (input valid, func, block_number, byte_count, flush_count, output ready);
endinterface

interface lbc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  kind;
	logic [lbc_pkg::BLK_W-1:0]   file_block;
	logic [lbc_pkg::CNT_W-1:0]   byte_offset;
	logic [lbc_pkg::CNT_W-1:0]   byte_length;
	logic [lbc_pkg::SLOT_W-1:0]  slot;
	logic                        found;
	logic                        clear_slot;
	logic                        last;

	modport source (output valid, kind, file_block, byte_offset, byte_length, slot, found,
		clear_slot, last, input ready);
	modport sink (input valid, kind, file_block, byte_offset, byte_length, slot, found,
		clear_slot, last, output ready);
endinterface

/* design/lbc_div.sv */
module lbc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lbc_pkg::BLK_W-1:0]  dividend,
	input  logic [lbc_pkg::CNT_W-1:0]  divisor,
	output logic                       done,
	output logic [lbc_pkg::BLK_W-1:0]  quot,
	output logic [lbc_pkg::CNT_W-1:0]  rem
);
	localparam int DW = lbc_pkg::BLK_W;
	localparam int VW = lbc_pkg::CNT_W;
	localparam int SW = $clog2(DW);
	localparam logic [SW-1:0] LAST_STEP = SW'(DW - 1);

	logic          busy_q;
	logic          done_q;
	logic [SW-1:0] step_q;
	logic [DW-1:0] quot_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [VW:0]   shifted;
	logic          fits;

	// one quotient bit per cycle, restoring form
	assign shifted = {rem_q, quot_q[DW-1]};
	assign fits = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + SW'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[DW-2:0], fits};
			rem_q <= fits ? VW'(shifted - {1'b0, dvs_q}) : shifted[VW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem = rem_q;
endmodule

/* design/lbc_datapath.sv */
module lbc_datapath #(
	parameter int N = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lbc_pkg::cmd_t               cmd,
	output lbc_pkg::status_t            sts,
	input  logic                        compact,
	input  logic [lbc_pkg::CNT_W-1:0]   fbb,
	input  logic [1:0]                  in_func,
	input  logic [lbc_pkg::BLK_W-1:0]   in_block,
	input  logic [lbc_pkg::CNT_W-1:0]   in_bytes,
	input  logic [lbc_pkg::FLC_W-1:0]   in_flush,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  out_kind,
	output logic [lbc_pkg::BLK_W-1:0]   out_block,
	output logic [lbc_pkg::CNT_W-1:0]   out_offset,
	output logic [lbc_pkg::CNT_W-1:0]   out_length,
	output logic [lbc_pkg::SLOT_W-1:0]  out_slot,
	output logic                        out_found,
	output logic                        out_clear,
	output logic                        out_last
);
	localparam int IW = $clog2(N);
	localparam int CW = $clog2(N + 1);
	localparam int BW = lbc_pkg::BLK_W;
	localparam int VW = lbc_pkg::CNT_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

	// tag and byte count stores
	logic [BW-1:0] tag_mem [N];
	logic [VW-1:0] bytes_mem [N];
	logic [BW-1:0] rd_tag_q;
	logic [VW-1:0] rd_bytes_q;
	logic [IW-1:0] rd_addr;

	logic [N-1:0]  valid_q;
	logic [N-1:0]  dirty_q;
	logic [IW-1:0] rank_q [N];
	logic [CW-1:0] cnt_q;
	logic [31:0]   hits_q;
	logic [31:0]   misses_q;
	logic [IW-1:0] sel_q;

	logic [1:0]                func_q;
	logic [BW-1:0]             no_q;
	logic [VW-1:0]             nbytes_q;
	logic [lbc_pkg::FLC_W-1:0] fcnt_q;

	logic          scan_run_q;
	logic [IW-1:0] scan_ptr_q;
	logic          scan_vld_s1;
	logic [IW-1:0] scan_idx_s1;
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic          free_q;
	logic [IW-1:0] free_idx_q;
	logic [IW-1:0] old_idx_q;
	logic [IW-1:0] old_rank;
	logic [IW-1:0] alloc_idx;
	logic [IW-1:0] hit_rank;

	logic [VW-1:0] bs;
	logic          div_done;
	logic [BW-1:0] quot;
	logic [VW-1:0] rem;
	logic [VW-1:0] remain;

	logic          out_valid_q;
	logic [1:0]    kind_q;
	logic [BW-1:0] block_q;
	logic [VW-1:0] offset_q;
	logic [VW-1:0] length_q;
	logic [IW-1:0] slot_q;
	logic          found_q;
	logic          clear_q;
	logic          last_q;

	assign old_rank = IW'(cnt_q - CW'(1));
	assign alloc_idx = free_q ? free_idx_q : old_idx_q;
	assign hit_rank = rank_q[hit_idx_q];
	assign rd_addr = cmd.read_old ? old_idx_q : scan_ptr_q;
	assign bs = (fbb == '0) ? VW'(1) : fbb;
	assign remain = bs - rem;

	// latch the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= '0;
		end else if (cmd.latch_in) begin
			fcnt_q <= in_flush;
		end else if (cmd.flush_dec) begin
			fcnt_q <= fcnt_q - lbc_pkg::FLC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			func_q <= in_func;
			no_q <= in_block;
			nbytes_q <= in_bytes;
		end
	end

	// store read and write ports
	always_ff @(posedge clk) begin
		if (scan_run_q || cmd.read_old) begin
			rd_tag_q <= tag_mem[rd_addr];
			rd_bytes_q <= bytes_mem[rd_addr];
		end
		if (cmd.alloc)
			tag_mem[alloc_idx] <= no_q;
		if (cmd.new_write)
			bytes_mem[sel_q] <= nbytes_q;
	end

	// walk every entry once: match, first free slot, least recent entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_run_q <= 1'b0;
			scan_ptr_q <= '0;
			scan_vld_s1 <= 1'b0;
			scan_idx_s1 <= '0;
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			free_q <= 1'b0;
			free_idx_q <= '0;
			old_idx_q <= '0;
		end else begin
			scan_vld_s1 <= scan_run_q;
			scan_idx_s1 <= scan_ptr_q;
			if (cmd.scan_start) begin
				scan_run_q <= 1'b1;
				scan_ptr_q <= '0;
				hit_q <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (scan_run_q) begin
					scan_ptr_q <= scan_ptr_q + IW'(1);
					if (scan_ptr_q == LAST_IDX)
						scan_run_q <= 1'b0;
				end
				if (scan_vld_s1) begin
					if (valid_q[scan_idx_s1] && rd_tag_q == no_q && !hit_q) begin
						hit_q <= 1'b1;
						hit_idx_q <= scan_idx_s1;
					end
					if (!valid_q[scan_idx_s1] && !free_q) begin
						free_q <= 1'b1;
						free_idx_q <= scan_idx_s1;
					end
					if (valid_q[scan_idx_s1] && rank_q[scan_idx_s1] == old_rank)
						old_idx_q <= scan_idx_s1;
				end
			end
		end
	end

	// entry flags, recency ranks and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			for (int i = 0; i < N; i++)
				rank_q[i] <= '0;
			cnt_q <= '0;
			hits_q <= '0;
			misses_q <= '0;
			sel_q <= '0;
		end else begin
			if (cmd.hit_inc)
				hits_q <= hits_q + 32'd1;
			if (cmd.miss_inc)
				misses_q <= misses_q + 32'd1;
			if (cmd.make_recent) begin
				for (int i = 0; i < N; i++)
					if (valid_q[i] && rank_q[i] < hit_rank)
						rank_q[i] <= rank_q[i] + IW'(1);
				rank_q[hit_idx_q] <= '0;
				sel_q <= hit_idx_q;
			end
			if (cmd.touch) begin
				dirty_q[hit_idx_q] <= 1'b1;
				sel_q <= hit_idx_q;
			end
			if (cmd.alloc) begin
				for (int i = 0; i < N; i++)
					if (valid_q[i])
						rank_q[i] <= rank_q[i] + IW'(1);
				valid_q[alloc_idx] <= 1'b1;
				dirty_q[alloc_idx] <= 1'b0;
				rank_q[alloc_idx] <= '0;
				cnt_q <= cnt_q + CW'(1);
				sel_q <= alloc_idx;
			end
			if (cmd.evict) begin
				valid_q[old_idx_q] <= 1'b0;
				dirty_q[old_idx_q] <= 1'b0;
				rank_q[old_idx_q] <= '0;
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.new_write)
				dirty_q[sel_q] <= 1'b1;
		end
	end

	lbc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (cmd.div_src_tag ? rd_tag_q : no_q),
		.divisor  (bs),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q <= lbc_pkg::K_WB;
			block_q <= '0;
			offset_q <= '0;
			length_q <= '0;
			slot_q <= old_idx_q;
			found_q <= 1'b0;
			clear_q <= 1'b0;
			last_q <= 1'b0;
			case (cmd.emit_code)
				lbc_pkg::EM_RESP: begin
					kind_q <= lbc_pkg::K_RESP;
					last_q <= 1'b1;
					found_q <= hit_q && func_q != lbc_pkg::F_FLUSH;
					clear_q <= func_q == lbc_pkg::F_NEW;
					if (func_q == lbc_pkg::F_FLUSH || (func_q == lbc_pkg::F_TOUCH && !hit_q))
						slot_q <= '0;
					else
						slot_q <= sel_q;
				end
				lbc_pkg::EM_WB_PLAIN: begin
					block_q <= rd_tag_q;
				end
				lbc_pkg::EM_WB_A: begin
					block_q <= quot;
					offset_q <= rem;
					length_q <= (remain < rd_bytes_q) ? remain : rd_bytes_q;
				end
				lbc_pkg::EM_WB_B: begin
					block_q <= quot + BW'(1);
					length_q <= rd_bytes_q - remain;
				end
				lbc_pkg::EM_FILL_PLAIN: begin
					kind_q <= lbc_pkg::K_FILL;
					block_q <= no_q;
					slot_q <= sel_q;
				end
				lbc_pkg::EM_FILL_A: begin
					kind_q <= lbc_pkg::K_FILL;
					block_q <= quot;
					offset_q <= rem;
					length_q <= remain;
					slot_q <= sel_q;
				end
				lbc_pkg::EM_FILL_B: begin
					kind_q <= lbc_pkg::K_FILL;
					block_q <= quot + BW'(1);
					length_q <= rem;
					slot_q <= sel_q;
				end
				default: begin
					kind_q <= lbc_pkg::K_RESP;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind = kind_q;
	assign out_block = block_q;
	assign out_offset = offset_q;
	assign out_length = length_q;
	assign out_slot = lbc_pkg::SLOT_W'(slot_q);
	assign out_found = found_q;
	assign out_clear = clear_q;
	assign out_last = last_q;

	// status toward the controller
	always_comb begin
		sts.scan_done = scan_vld_s1 && scan_idx_s1 == LAST_IDX;
		sts.hit = hit_q;
		sts.free_found = free_q;
		sts.old_dirty = dirty_q[old_idx_q];
		sts.cnt_zero = cnt_q == '0;
		sts.fcnt_zero = fcnt_q == '0;
		sts.div_done = div_done;
		sts.wb_split = remain < rd_bytes_q;
		sts.fill_split = rem != '0;
		sts.out_free = !out_valid_q || out_ready;
		sts.compact = compact;
		sts.func = func_q;
	end
endmodule

/* design/lbc_ctrl.sv */
module lbc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  lbc_pkg::status_t  sts,
	output lbc_pkg::cmd_t     cmd
);
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_SCAN = 5'd1;
	localparam logic [4:0] S_DECIDE = 5'd2;
	localparam logic [4:0] S_EV_RD = 5'd3;
	localparam logic [4:0] S_EV_CHK = 5'd4;
	localparam logic [4:0] S_EV_WB = 5'd5;
	localparam logic [4:0] S_EV_DIV = 5'd6;
	localparam logic [4:0] S_EV_WBA = 5'd7;
	localparam logic [4:0] S_EV_WBB = 5'd8;
	localparam logic [4:0] S_EV_UPD = 5'd9;
	localparam logic [4:0] S_FL_NEXT = 5'd10;
	localparam logic [4:0] S_ALLOC = 5'd11;
	localparam logic [4:0] S_FILL = 5'd12;
	localparam logic [4:0] S_FILL_DIV = 5'd13;
	localparam logic [4:0] S_FILL_A = 5'd14;
	localparam logic [4:0] S_FILL_B = 5'd15;
	localparam logic [4:0] S_NEWW = 5'd16;
	localparam logic [4:0] S_RESP = 5'd17;

	logic [4:0] state_q;
	logic [4:0] state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nxt;
	end

	assign req_ready = state_q == S_IDLE;

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch_in = 1'b1;
					cmd.scan_start = 1'b1;
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_done)
					state_nxt = S_DECIDE;
			end
			S_DECIDE: begin
				case (sts.func)
					lbc_pkg::F_READ: begin
						if (sts.hit) begin
							cmd.make_recent = 1'b1;
							cmd.hit_inc = 1'b1;
							state_nxt = S_RESP;
						end else begin
							cmd.miss_inc = 1'b1;
							state_nxt = sts.free_found ? S_ALLOC : S_EV_RD;
						end
					end
					lbc_pkg::F_NEW: begin
						if (sts.hit) begin
							cmd.make_recent = 1'b1;
							state_nxt = S_NEWW;
						end else begin
							state_nxt = sts.free_found ? S_ALLOC : S_EV_RD;
						end
					end
					lbc_pkg::F_TOUCH: begin
						cmd.touch = sts.hit;
						state_nxt = S_RESP;
					end
					default: begin
						state_nxt = (sts.fcnt_zero || sts.cnt_zero) ? S_RESP : S_EV_RD;
					end
				endcase
			end
			S_EV_RD: begin
				cmd.read_old = 1'b1;
				state_nxt = S_EV_CHK;
			end
			S_EV_CHK: begin
				if (!sts.old_dirty) begin
					state_nxt = S_EV_UPD;
				end else if (!sts.compact) begin
					state_nxt = S_EV_WB;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_src_tag = 1'b1;
					state_nxt = S_EV_DIV;
				end
			end
			S_EV_WB: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_code = lbc_pkg::EM_WB_PLAIN;
					state_nxt = S_EV_UPD;
				end
			end
			S_EV_DIV: begin
				if (sts.div_done)
					state_nxt = S_EV_WBA;
			end
			S_EV_WBA: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_code = lbc_pkg::EM_WB_A;
					state_nxt = sts.wb_split ? S_EV_WBB : S_EV_UPD;
				end
			end
			S_EV_WBB: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_code = lbc_pkg::EM_WB_B;
					state_nxt = S_EV_UPD;
				end
			end
			S_EV_UPD: begin
				cmd.evict = 1'b1;
				if (sts.func == lbc_pkg::F_FLUSH) begin
					cmd.flush_dec = 1'b1;
					state_nxt = S_FL_NEXT;
				end else begin
					state_nxt = S_ALLOC;
				end
			end
			S_FL_NEXT: begin
				if (sts.fcnt_zero || sts.cnt_zero) begin
					state_nxt = S_RESP;
				end else begin
					cmd.scan_start = 1'b1;
					state_nxt = S_SCAN;
				end
			end
			S_ALLOC: begin
				cmd.alloc = 1'b1;
				state_nxt = (sts.func == lbc_pkg::F_READ) ? S_FILL : S_NEWW;
			end
			S_FILL: begin
				if (sts.compact) begin
					cmd.div_start = 1'b1;
					state_nxt = S_FILL_DIV;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_code = lbc_pkg::EM_FILL_PLAIN;
					state_nxt = S_RESP;
				end
			end
			S_FILL_DIV: begin
				if (sts.div_done)
					state_nxt = S_FILL_A;
			end
			S_FILL_A: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_code = lbc_pkg::EM_FILL_A;
					state_nxt = sts.fill_split ? S_FILL_B : S_RESP;
				end
			end
			S_FILL_B: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_code = lbc_pkg::EM_FILL_B;
					state_nxt = S_RESP;
				end
			end
			S_NEWW: begin
				cmd.new_write = 1'b1;
				state_nxt = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_code = lbc_pkg::EM_RESP;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end
endmodule

/* design/lru_block_cache_directory.sv */
// Fully associative write-back block cache directory with LRU replacement.
// One request (read, new, touch, flush) is taken at a time; each yields zero
// or more write-back and fill words and then one response word with last set.
// Every request starts with a walk over all CACHE_SLOTS entries through the
// single read port of the tag store, one entry a cycle. In compact mode each
// split of a byte position into file block and offset runs through a radix-2
// divider; a read miss that evicts a dirty entry needs two of them. A flush
// repeats the walk and eviction for every entry it drops. Output stalls hold
// back each emitted word.
module lru_block_cache_directory #(
	parameter int CACHE_SLOTS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	lbc_req_if.sink      req,
	lbc_rsp_if.source    rsp,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	logic                        compact_q;
	logic [lbc_pkg::CNT_W-1:0]   fbb_q;
	logic                        cfg_wr;
	lbc_pkg::cmd_t               cmd;
	lbc_pkg::status_t            sts;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compact_q <= 1'b0;
			fbb_q <= 16'd4096;
		end else if (cfg_wr) begin
			case (paddr[2])
				lbc_pkg::REG_COMPACT: compact_q <= pwdata[0];
				lbc_pkg::REG_FBB: fbb_q <= pwdata[lbc_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			lbc_pkg::REG_COMPACT: prdata = {31'd0, compact_q};
			lbc_pkg::REG_FBB: prdata = {16'd0, fbb_q};
			default: prdata = '0;
		endcase
	end

	lbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lbc_datapath #(.N(CACHE_SLOTS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.compact    (compact_q),
		.fbb        (fbb_q),
		.in_func    (req.func),
		.in_block   (req.block_number),
		.in_bytes   (req.byte_count),
		.in_flush   (req.flush_count),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_kind   (rsp.kind),
		.out_block  (rsp.file_block),
		.out_offset (rsp.byte_offset),
		.out_length (rsp.byte_length),
		.out_slot   (rsp.slot),
		.out_found  (rsp.found),
		.out_clear  (rsp.clear_slot),
		.out_last   (rsp.last)
	);

	// a taken request drops ready in the cycle after it is accepted
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while previous one in work");

	// only the response word closes a request
	a_last_is_resp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.last == (rsp.kind == lbc_pkg::K_RESP)))
		else $error("last flag does not match word kind");

	// commands appear only while a request is in work
	a_cmd_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.kind != lbc_pkg::K_RESP) |-> !req.ready)
		else $error("command word while idle");
endmodule

/* verif/lbc_checker.sv */
`timescale 1ns / 100ps

module lbc_checker (
	input  logic        clk,
	input  logic        arst_n,
	lbc_req_if          req,
	lbc_rsp_if          rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending,
	output int          words_seen,
	output int          hits,
	output int          misses
);

	localparam int BW = lbc_pkg::BLK_W;
	localparam int CW = lbc_pkg::CNT_W;
	localparam int SW = lbc_pkg::SLOT_W;
	localparam int FW = lbc_pkg::FLC_W;

	typedef struct packed {
		logic [1:0]    kind;
		logic [BW-1:0] fblk;
		logic [CW-1:0] offs;
		logic [CW-1:0] blen;
		logic [SW-1:0] slot;
		logic          found;
		logic          clr;
		logic          last;
	} dir_word_t;

	localparam int SLOTS = 16;

	// directory copy and register shadow
	logic [BW-1:0] tag_q [SLOTS];
	bit            vld_q [SLOTS];
	bit            drt_q [SLOTS];
	logic [CW-1:0] nbytes_q [SLOTS];
	int            rank_q [SLOTS];
	bit            cmode;
	logic [CW-1:0] fbb;

	dir_word_t expected_words[$];

	function automatic int unsigned blk_size();
		return (fbb == 0) ? 32'd1 : 32'(fbb);
	endfunction

	function automatic void put(logic [1:0] k, logic [BW-1:0] fb, logic [CW-1:0] off,
		logic [CW-1:0] len, int s, bit fnd, bit clr, bit lst);
		dir_word_t w;
		w.kind = k;
		w.fblk = fb;
		w.offs = off;
		w.blen = len;
		w.slot = s[SW-1:0];
		w.found = fnd;
		w.clr = clr;
		w.last = lst;
		expected_words.push_back(w);
	endfunction

	function automatic int lookup(logic [BW-1:0] bn);
		for (int i = 0; i < SLOTS; i++)
			if (vld_q[i] && tag_q[i] == bn) return i;
		return -1;
	endfunction

	function automatic int live_count();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++) if (vld_q[i]) n++;
		return n;
	endfunction

	function automatic void promote(int s);
		int r;
		r = rank_q[s];
		for (int i = 0; i < SLOTS; i++)
			if (vld_q[i] && rank_q[i] < r) rank_q[i]++;
		rank_q[s] = 0;
	endfunction

	// drop the least recent entry, writing it back when dirty
	function automatic void evict_lru();
		int s;
		int unsigned bs, fb, off, remain, nb;
		s = -1;
		for (int i = 0; i < SLOTS; i++)
			if (vld_q[i] && (s < 0 || rank_q[i] > rank_q[s])) s = i;
		if (s < 0) return;
		if (drt_q[s]) begin
			if (!cmode) begin
				put(lbc_pkg::K_WB, tag_q[s], 0, 0, s, 0, 0, 0);
			end else begin
				bs = blk_size();
				fb = 32'(tag_q[s]) / bs;
				off = 32'(tag_q[s]) - fb * bs;
				remain = bs - off;
				nb = 32'(nbytes_q[s]);
				if (remain >= nb) begin
					put(lbc_pkg::K_WB, BW'(fb), CW'(off), CW'(nb), s, 0, 0, 0);
				end else begin
					put(lbc_pkg::K_WB, BW'(fb), CW'(off), CW'(remain), s, 0, 0, 0);
					put(lbc_pkg::K_WB, BW'(fb + 32'd1), 0, CW'(nb - remain), s, 0, 0, 0);
				end
			end
		end
		vld_q[s] = 0;
		drt_q[s] = 0;
		rank_q[s] = 0;
	endfunction

	function automatic int allocate(logic [BW-1:0] bn);
		int s;
		s = -1;
		for (int i = 0; i < SLOTS && s < 0; i++) if (!vld_q[i]) s = i;
		if (s < 0) begin
			evict_lru();
			for (int i = 0; i < SLOTS && s < 0; i++) if (!vld_q[i]) s = i;
		end
		if (s < 0) s = 0;
		for (int i = 0; i < SLOTS; i++) if (vld_q[i]) rank_q[i]++;
		vld_q[s] = 1;
		drt_q[s] = 0;
		tag_q[s] = bn;
		rank_q[s] = 0;
		return s;
	endfunction

	// work out every word one request causes
	function automatic void predict_request(logic [1:0] op, logic [BW-1:0] bn,
		logic [CW-1:0] nb, logic [FW-1:0] cnt);
		int s;
		bit present;
		int unsigned bs, fb, off;
		case (op)
			lbc_pkg::F_READ: begin
				s = lookup(bn);
				if (s >= 0) begin
					promote(s);
					hits++;
					put(lbc_pkg::K_RESP, 0, 0, 0, s, 1, 0, 1);
				end else begin
					misses++;
					s = allocate(bn);
					if (!cmode) begin
						put(lbc_pkg::K_FILL, bn, 0, 0, s, 0, 0, 0);
					end else begin
						bs = blk_size();
						fb = 32'(bn) / bs;
						off = 32'(bn) - fb * bs;
						put(lbc_pkg::K_FILL, BW'(fb), CW'(off), CW'(bs - off), s, 0, 0, 0);
						if (off > 0)
							put(lbc_pkg::K_FILL, BW'(fb + 32'd1), 0, CW'(off), s, 0, 0, 0);
					end
					put(lbc_pkg::K_RESP, 0, 0, 0, s, 0, 0, 1);
				end
			end
			lbc_pkg::F_NEW: begin
				present = 0;
				s = lookup(bn);
				if (s >= 0) begin
					promote(s);
					present = 1;
				end else begin
					s = allocate(bn);
				end
				drt_q[s] = 1;
				nbytes_q[s] = nb;
				put(lbc_pkg::K_RESP, 0, 0, 0, s, present, 1, 1);
			end
			lbc_pkg::F_TOUCH: begin
				s = lookup(bn);
				if (s >= 0) begin
					drt_q[s] = 1;
					put(lbc_pkg::K_RESP, 0, 0, 0, s, 1, 0, 1);
				end else begin
					put(lbc_pkg::K_RESP, 0, 0, 0, 0, 0, 0, 1);
				end
			end
			default: begin
				for (int i = 0; i < cnt && live_count() > 0; i++) evict_lru();
				put(lbc_pkg::K_RESP, 0, 0, 0, 0, 0, 0, 1);
			end
		endcase
	endfunction

	always @(posedge clk) begin
		dir_word_t got, exp_w;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				vld_q[i] = 0;
				drt_q[i] = 0;
				rank_q[i] = 0;
			end
			cmode = 0;
			fbb = 16'd4096;
			fail_count = 0;
			words_seen = 0;
			hits = 0;
			misses = 0;
		end else begin
			// track register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == lbc_pkg::REG_COMPACT) cmode = pwdata[0];
				else fbb = pwdata[CW-1:0];
			end
			// retire an output word against the oldest expectation
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.kind, rsp.file_block, rsp.byte_offset, rsp.byte_length, rsp.slot,
					rsp.found, rsp.clear_slot, rsp.last};
				words_seen++;
				if (expected_words.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected word kind=%0d fb=%h off=%0d len=%0d slot=%0d",
							$time, got.kind, got.fblk, got.offs, got.blen, got.slot);
				end else begin
					exp_w = expected_words.pop_front();
					if (got.kind !== exp_w.kind || got.fblk !== exp_w.fblk ||
						got.offs !== exp_w.offs || got.blen !== exp_w.blen ||
						got.slot !== exp_w.slot || got.found !== exp_w.found ||
						got.clr !== exp_w.clr || got.last !== exp_w.last) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display({"%0t: mismatch exp kind=%0d fb=%h off=%0d len=%0d",
								" slot=%0d f=%0d c=%0d l=%0d"},
								$time, exp_w.kind, exp_w.fblk, exp_w.offs, exp_w.blen,
								exp_w.slot, exp_w.found, exp_w.clr, exp_w.last);
							$display({"%0t:          got kind=%0d fb=%h off=%0d len=%0d",
								" slot=%0d f=%0d c=%0d l=%0d"},
								$time, got.kind, got.fblk, got.offs, got.blen,
								got.slot, got.found, got.clr, got.last);
						end
					end
				end
			end
			// accepted request
			if (req.valid && req.ready)
				predict_request(req.func, req.block_number, req.byte_count, req.flush_count);
		end
		pending = expected_words.size();
	end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

	localparam int LIMIT = 1500000;
	localparam int POOL = 20;
	localparam int BW = lbc_pkg::BLK_W;
	localparam int CW = lbc_pkg::CNT_W;
	localparam int FW = lbc_pkg::FLC_W;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int fail_count, pending, words_seen, hits, misses;
	int snd_idle, rcv_idle;
	int hold_len;
	int cycles;
	int items_sent;
	logic [BW-1:0] pool [POOL];

	lbc_req_if req ();
	lbc_rsp_if rsp ();

	lru_block_cache_directory DUT (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	lbc_checker u_checker (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending),
		.words_seen(words_seen), .hits(hits), .misses(misses)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// abort on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("lru_block_cache_directory regression: fail");
			$finish;
		end
	end

	// output side: random stalls plus one long hold
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_len > 0) begin
			rsp.ready <= 1'b0;
			hold_len = hold_len - 1;
		end else begin
			rsp.ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// offer one request word, leave valid high afterward
	task automatic send(logic [1:0] op, logic [BW-1:0] bn, logic [CW-1:0] nb,
		logic [FW-1:0] cnt);
		if ($urandom_range(99) < snd_idle) begin
			req.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle);
		end
		req.valid <= 1'b1;
		req.func <= op;
		req.block_number <= bn;
		req.byte_count <= nb;
		req.flush_count <= cnt;
		do @(posedge clk); while (!req.ready);
		items_sent++;
	endtask

	// lower valid and let the block drain
	task automatic drain();
		req.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic random_request();
		int roll;
		logic [BW-1:0] bn;
		logic [CW-1:0] nb;
		roll = $urandom_range(99);
		if ($urandom_range(9) == 0) pool[$urandom_range(POOL-1)] = BW'($urandom);
		bn = ($urandom_range(9) == 0) ? BW'($urandom) : pool[$urandom_range(POOL-1)];
		nb = ($urandom_range(1)) ? CW'($urandom) : CW'($urandom_range(300));
		if (roll < 45) send(lbc_pkg::F_READ, bn, nb, FW'($urandom_range(16)));
		else if (roll < 72) send(lbc_pkg::F_NEW, bn, nb, FW'($urandom_range(16)));
		else if (roll < 90) send(lbc_pkg::F_TOUCH, bn, nb, FW'($urandom_range(16)));
		else send(lbc_pkg::F_FLUSH, bn, nb, FW'($urandom_range(16)));
	endtask

	initial begin
		logic [CW-1:0] fbb_set [6];
		bit cmode_set [6];
		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		req.valid = 0; req.func = lbc_pkg::F_READ; req.block_number = 0;
		req.byte_count = 0; req.flush_count = 0;
		snd_idle = 30; rcv_idle = 61;
		hold_len = 0; cycles = 0; items_sent = 0;
		cmode_set = '{0, 1, 1, 1, 1, 0};
		fbb_set = '{16'd4096, 16'd4096, 16'd1, 16'hFFFF,
			CW'($urandom_range(2, 5000)), CW'($urandom_range(1, 65535))};
		for (int i = 0; i < POOL; i++) pool[i] = BW'($urandom);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin snd_idle = 61; rcv_idle = 30; end
			if (ph == 4) begin snd_idle = 0; rcv_idle = 0; end
			cfg_write(3'(lbc_pkg::REG_COMPACT) << 2, 32'(cmode_set[ph]));
			cfg_write(3'(lbc_pkg::REG_FBB) << 2, 32'(fbb_set[ph]));
			if (ph == 0) begin
				// fill every slot with new so each slot holds a byte count
				for (int i = 0; i < 16; i++)
					send(lbc_pkg::F_NEW, (i == 0) ? '0 : (i == 15) ? '1 : {27'($urandom), 4'(i)},
						(i == 0) ? '0 : (i == 15) ? '1 : CW'($urandom), 5'd0);
				send(lbc_pkg::F_READ, '1, 0, 0);
				send(lbc_pkg::F_READ, BW'($urandom), 0, 0);
				send(lbc_pkg::F_TOUCH, '0, 0, 0);
				send(lbc_pkg::F_TOUCH, 31'h2AAA5555, 0, 0);
				send(lbc_pkg::F_NEW, '1, 16'd77, 0);
				send(lbc_pkg::F_FLUSH, 0, 0, 5'd0);
				send(lbc_pkg::F_FLUSH, 0, 0, 5'd3);
				send(lbc_pkg::F_FLUSH, 0, 0, 5'd16);
				send(lbc_pkg::F_READ, 31'h55555555, 0, 0);
				drain();
			end
			if (ph == 2) begin
				// last file block: write-back split wraps to block zero
				send(lbc_pkg::F_NEW, '1, 16'd5, 0);
				send(lbc_pkg::F_FLUSH, 0, 0, 5'd16);
			end
			// long output hold while requests keep coming
			if (ph == 1) hold_len = 400;
			for (int n = 0; n < 45; n++) random_request();
			drain();
		end

		$display("requests %0d, words checked %0d, read hits %0d, read misses %0d",
			items_sent, words_seen, hits, misses);
		$display("six register settings, compact and plain addressing, three stall profiles");
		if (fail_count == 0)
			$display("lru_block_cache_directory regression: pass");
		else
			$display("lru_block_cache_directory regression: fail");
		$finish;
	end

endmodule
